// File: rtl/ilc_pkg.sv
package ilc_pkg;

    localparam int MODE_W  = 3;
    localparam int INDEX_W = 6;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [MODE_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_GET    = 3'd3,
        OP_SET    = 3'd4
    } t_op;

    // per-cycle control broadcast to every cell of the row
    typedef struct packed {
        logic cap;    // capture read data this cycle
        logic rd;     // a successful read is under way
        logic wr;     // a successful push or set is under way
        logic shift;  // a successful remove is under way
    } t_cell_ctl;

endpackage

// File: rtl/ilc_if.sv
interface ilc_req_if;
    logic                            valid;
    logic                            ready;
    logic [ilc_pkg::MODE_W-1:0]      mode;
    logic [ilc_pkg::INDEX_W-1:0]     index;
    logic [ilc_pkg::DATA_W-1:0]      value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

interface ilc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            ok;
    logic [ilc_pkg::DATA_W-1:0]      read_value;
    logic [ilc_pkg::COUNT_W-1:0]     count;

    modport source (output valid, output ok, output read_value, output count, input ready);
    modport sink   (input valid, input ok, input read_value, input count, output ready);
endinterface

// File: rtl/ilc_cell.sv
module ilc_cell #(
    parameter int ELEM_WIDTH = 32,
    parameter int CW         = 7,
    parameter int POS        = 0
) (
    input  logic                  i_clk,
    input  ilc_pkg::t_cell_ctl    i_ctl,
    input  logic [CW-1:0]         i_wr_pos,
    input  logic [CW-1:0]         i_rd_pos,
    input  logic [CW-1:0]         i_lo,
    input  logic [CW-1:0]         i_hi,
    input  logic [ELEM_WIDTH-1:0] i_val,
    input  logic [ELEM_WIDTH-1:0] i_next,
    output logic [ELEM_WIDTH-1:0] o_data,
    output logic [ELEM_WIDTH-1:0] o_rd
);
    import ilc_pkg::*;

    localparam logic [CW-1:0] POS_C  = CW'(POS);
    localparam logic [CW-1:0] POS_P1 = CW'(POS + 1);

    logic [ELEM_WIDTH-1:0] r_data;
    logic [ELEM_WIDTH-1:0] r_rd;

    // element store: direct write or take the upper neighbor on compaction
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && (POS_C == i_wr_pos)) begin
            r_data <= i_val;
        end else if (i_ctl.shift && (POS_C >= i_lo) && (POS_P1 < i_hi)) begin
            r_data <= i_next;
        end
    end

    // masked read share, or-ed together at the top
    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_rd <= (i_ctl.rd && (POS_C == i_rd_pos)) ? r_data : '0;
        end
    end

    assign o_data = r_data;
    assign o_rd   = r_rd;

endmodule

// File: rtl/indexed_list_with_compaction_top.sv
// indexed list with compaction on remove
//
// requests arrive on i_req (mode, index, value) and each gives exactly one
// response on o_rsp (ok, read_value, count). a transaction moves on a
// channel at a rising edge of i_clk where valid and ready are both high.
//
// the list lives in a row of DEPTH cells, one element per cell. a remove
// makes every live cell from the index up to the next-to-last one load its upper neighbor in the same
// cycle, so compaction costs nothing extra.
//
// timing: a request accepted in the idle state executes in the row in the
// execute step, and its response is registered in the reduce step. the
// block takes a new request only after the last has passed accept, execute in
// the cells, then or-reduce the per-cell read shares into the response.
// a finished response waiting on o_rsp does not keep the next request out;
// only if a second response is ready while the first is still held does the
// reduce step wait for the receiver, and the input stays closed meanwhile.
//
// reset (i_rst_n low, synchronous) empties the list and drops any pending
// request or response. cell contents are not cleared; only live cells are
// ever read.
module indexed_list_with_compaction_top #(
    parameter int DEPTH      = 64,
    parameter int ELEM_WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ilc_req_if.sink   i_req,
    ilc_rsp_if.source o_rsp
);
    import ilc_pkg::*;

    // count width covers DEPTH itself and at least the 7-bit count field
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_EXEC   = 3'b010,
        ST_REDUCE = 3'b100
    } t_state;

    t_state r_state, n_state;

    // captured request
    logic [MODE_W-1:0]     r_mode;
    logic [INDEX_W-1:0]    r_idx;
    logic [ELEM_WIDTH-1:0] r_val;
    logic [ELEM_WIDTH-1:0] val_cut;

    logic [CW-1:0] r_count, n_count;
    logic          r_res_ok;

    // response register
    logic              r_out_valid;
    logic              r_out_ok;
    logic [DATA_W-1:0] r_out_rd;
    logic [COUNT_W-1:0] r_out_cnt;

    logic in_fire, out_fire, out_load;

    // execute-step decode
    t_cell_ctl     ctl;
    logic          ok_c;
    logic [CW-1:0] idx_ext;
    logic [CW-1:0] wr_pos, rd_pos;

    // row wiring
    logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
    logic [ELEM_WIDTH-1:0] cell_rd   [DEPTH];
    logic [ELEM_WIDTH-1:0] rd_or;
    logic [DATA_W-1:0]     rd_out;

    assign in_fire  = i_req.valid && i_req.ready;
    assign out_fire = o_rsp.valid && o_rsp.ready;
    assign out_load = (r_state == ST_REDUCE) && (!r_out_valid || o_rsp.ready);

    assign i_req.ready = (r_state == ST_IDLE);

    // cut or widen the incoming value to the element width, and the read data to DATA_W
    generate
        if (ELEM_WIDTH <= DATA_W) begin : g_val_narrow
            assign val_cut = i_req.value[ELEM_WIDTH-1:0];
            assign rd_out  = DATA_W'(rd_or);
        end else begin : g_val_wide
            assign val_cut = ELEM_WIDTH'(i_req.value);
            assign rd_out  = rd_or[DATA_W-1:0];
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_fire) n_state = ST_EXEC;
            ST_EXEC:   n_state = ST_REDUCE;
            ST_REDUCE: if (out_load) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // request decode against the live count
    always_comb begin
        idx_ext   = CW'(r_idx);
        ok_c      = 1'b0;
        wr_pos    = idx_ext;
        rd_pos    = idx_ext;
        n_count   = r_count;
        ctl       = '0;
        ctl.cap   = (r_state == ST_EXEC);
        case (r_mode)
            OP_PUSH: begin
                ok_c   = (r_count < DEPTH_C);
                wr_pos = r_count;
                ctl.wr = ok_c;
                if (ok_c) n_count = r_count + CW'(1);
            end
            OP_POP: begin
                ok_c   = (r_count != '0);
                rd_pos = r_count - CW'(1);
                ctl.rd = ok_c;
                if (ok_c) n_count = r_count - CW'(1);
            end
            OP_REMOVE: begin
                ok_c      = (idx_ext < r_count);
                ctl.rd    = ok_c;
                ctl.shift = ok_c;
                if (ok_c) n_count = r_count - CW'(1);
            end
            OP_GET: begin
                ok_c   = (idx_ext < r_count);
                ctl.rd = ok_c;
            end
            OP_SET: begin
                ok_c   = (idx_ext < r_count);
                ctl.wr = ok_c;
            end
            default: ok_c = 1'b0;
        endcase
        // the row only acts during the execute step
        if (r_state != ST_EXEC) begin
            ctl.rd    = 1'b0;
            ctl.wr    = 1'b0;
            ctl.shift = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EXEC) r_count <= n_count;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_fire) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_mode <= i_req.mode;
            r_idx  <= i_req.index;
            r_val  <= val_cut;
        end
        if (r_state == ST_EXEC) r_res_ok <= ok_c;
        if (out_load) begin
            r_out_ok  <= r_res_ok;
            r_out_rd  <= rd_out;
            r_out_cnt <= r_count[COUNT_W-1:0];
        end
    end

    // the row of cells; each one but the last sees its upper neighbor for compaction
    generate
        for (genvar g = 0; g < DEPTH; g++) begin : g_cell
            logic [ELEM_WIDTH-1:0] next_data;
            if (g == DEPTH - 1) begin : g_last
                assign next_data = '0;
            end else begin : g_mid
                assign next_data = cell_data[g+1];
            end
            ilc_cell #(
                .ELEM_WIDTH (ELEM_WIDTH),
                .CW         (CW),
                .POS        (g)
            ) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (ctl),
                .i_wr_pos (wr_pos),
                .i_rd_pos (rd_pos),
                .i_lo     (idx_ext),
                .i_hi     (r_count),
                .i_val    (r_val),
                .i_next   (next_data),
                .o_data   (cell_data[g]),
                .o_rd     (cell_rd[g])
            );
        end
    endgenerate

    // at most one cell holds a nonzero share, so an or gives the read data
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.ok         = r_out_ok;
    assign o_rsp.read_value = r_out_rd;
    assign o_rsp.count      = r_out_cnt;

    // the live count never passes the depth of the row
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("live count above depth");

    // an accepted request always goes to the execute step next
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state == ST_EXEC))
        else $error("accepted request not executed");

    // a successful push grows the count by exactly one
    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_mode == OP_PUSH && ok_c)
            |=> (r_count == $past(r_count) + CW'(1)))
        else $error("push did not grow count");

    // a failed operation returns no data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ok) |-> (o_rsp.read_value == '0))
        else $error("failed operation returned data");

    // a new response is not loaded over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready && r_state == ST_REDUCE) |=> (r_state == ST_REDUCE))
        else $error("response overwritten");

endmodule

// File: verif/indexed_list_with_compaction_top_tb.sv
`timescale 1ns / 1ps

module indexed_list_with_compaction_top_tb;

    import ilc_pkg::*;

    localparam int DEPTH      = 64;
    localparam int ELEM_WIDTH = 32;
    localparam int N_PHASES   = 17;
    localparam int PHASE_LEN  = 100;
    localparam int LONG_HOLD  = 300;   // receiver hold-off while the sender keeps pushing
    localparam int DRAIN_WAIT = 8;     // margin for responses still in flight
    localparam time RUN_LIMIT = 2_000_000;

    // modes with no operation behind them
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam logic [DATA_W-1:0] ALL_ONES = '1;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    typedef struct packed {
        logic                ok;
        logic [DATA_W-1:0]   read_value;
        logic [COUNT_W-1:0]  count;
    } t_list_rsp;

    // list predictor plus the queue of responses still owed by the block
    class list_scoreboard;
        logic [DATA_W-1:0] cells [DEPTH];
        int unsigned       live;
        t_list_rsp         owed_q[$];
        int                n_errors;
        int                n_requests;
        int                n_refused;
        int                n_full_hits;
        int                n_empty_hits;
        int                n_compactions;

        function new();
            live = 0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task report(string what);
            $display("ERROR at %0t: %s", $time, what);
            n_errors++;
        endtask

        // apply one accepted request to the shadow list and queue its response
        task note_request(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] index,
                          logic [DATA_W-1:0] value);
            t_list_rsp r;
            logic      in_range;
            r        = '0;
            in_range = (index < live);
            n_requests++;
            case (mode)
                OP_PUSH: begin
                    if (live < DEPTH) begin
                        cells[live] = value;
                        live++;
                        r.ok = 1'b1;
                    end else begin
                        n_full_hits++;
                    end
                end
                OP_POP: begin
                    if (live > 0) begin
                        live--;
                        r.read_value = cells[live];
                        r.ok = 1'b1;
                    end else begin
                        n_empty_hits++;
                    end
                end
                OP_REMOVE: begin
                    if (in_range) begin
                        r.read_value = cells[index];
                        for (int i = index; i + 1 < live; i++)
                            cells[i] = cells[i+1];
                        live--;
                        r.ok = 1'b1;
                        n_compactions++;
                    end
                end
                OP_GET: begin
                    if (in_range) begin
                        r.read_value = cells[index];
                        r.ok = 1'b1;
                    end
                end
                OP_SET: begin
                    if (in_range) begin
                        cells[index] = value;
                        r.ok = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!r.ok)
                n_refused++;
            r.count = live[COUNT_W-1:0];
            owed_q.push_back(r);
        endtask

        task check_response(logic ok, logic [DATA_W-1:0] read_value,
                            logic [COUNT_W-1:0] count);
            t_list_rsp e;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected response ok=%0b read_value=%08h count=%0d",
                                 ok, read_value, count));
                return;
            end
            e = owed_q.pop_front();
            if (ok !== e.ok)
                report($sformatf("ok %0b, expected %0b", ok, e.ok));
            if (read_value !== e.read_value)
                report($sformatf("read_value %08h, expected %08h",
                                 read_value, e.read_value));
            if (count !== e.count)
                report($sformatf("count %0d, expected %0d", count, e.count));
        endtask

        task check_leftovers();
            if (owed_q.size() != 0)
                report($sformatf("%0d responses never arrived", owed_q.size()));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    ilc_req_if req_if ();
    ilc_rsp_if rsp_if ();

    list_scoreboard sb;
    bit             long_hold_req;

    indexed_list_with_compaction_top #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #(RUN_LIMIT);
        $display("timeout: %0d responses still owed", sb.pending());
        $display("simulation failed");
        $finish;
    end

    // gap lengths: mostly none, sometimes short, rarely long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // mode mix depends on whether the phase should grow, shrink or churn the list
    function automatic logic [MODE_W-1:0] pick_mode(t_phase ph);
        int r;
        int w_push, w_pop, w_rem, w_get, w_set;
        r = $urandom_range(0, 99);
        case (ph)
            PH_FILL:  begin w_push = 70; w_pop = 5;  w_rem = 5;  w_get = 8;  w_set = 8;  end
            PH_DRAIN: begin w_push = 15; w_pop = 35; w_rem = 30; w_get = 8;  w_set = 8;  end
            default:  begin w_push = 25; w_pop = 15; w_rem = 15; w_get = 20; w_set = 20; end
        endcase
        if (r < w_push) return OP_PUSH;
        r -= w_push;
        if (r < w_pop) return OP_POP;
        r -= w_pop;
        if (r < w_rem) return OP_REMOVE;
        r -= w_rem;
        if (r < w_get) return OP_GET;
        r -= w_get;
        if (r < w_set) return OP_SET;
        return MODE_W'(MODE_SPARE_LO + $urandom_range(0, MODE_SPARE_HI - MODE_SPARE_LO));
    endfunction

    // index mostly inside the live part, sometimes past it, sometimes anywhere
    function automatic logic [INDEX_W-1:0] pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75 && sb.live > 0)
            return INDEX_W'($urandom_range(0, sb.live - 1));
        else if (r < 85 && sb.live < DEPTH)
            return INDEX_W'($urandom_range(sb.live, DEPTH - 1));
        else
            return INDEX_W'($urandom_range(0, DEPTH - 1));
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return ALL_ONES;
        else
            return $urandom;
    endfunction

    // keep the request channel quiet with valid low for the requested gap
    task automatic idle_req(int n);
        repeat (n) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
    endtask

    // offer one request and wait for its transaction
    task automatic send_req(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] index,
                            logic [DATA_W-1:0] value);
        @(negedge i_clk);
        req_if.valid <= 1'b1;
        req_if.mode  <= mode;
        req_if.index <= index;
        req_if.value <= value;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        sb.note_request(mode, index, value);
    endtask

    task automatic send_gapped(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] index,
                               logic [DATA_W-1:0] value);
        idle_req(rand_gap());
        send_req(mode, index, value);
    endtask

    // pause the sender until every owed response is back
    task automatic wait_drained();
        while (sb.pending() != 0) begin
            @(negedge i_clk);
            req_if.valid <= 1'b0;
        end
    endtask

    // response channel: random ready pattern, plus one long hold-off on request
    initial begin
        rsp_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                // counted here so the sender keeps offering while the block backs up
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    rsp_if.ready <= 1'b0;
                end
                long_hold_req = 1'b0;
            end else if ($urandom_range(0, 9) == 0) begin
                // a stretch with no stalls at all
                repeat ($urandom_range(50, 150)) begin
                    @(negedge i_clk);
                    rsp_if.ready <= 1'b1;
                end
            end else begin
                repeat ($urandom_range(1, 8)) begin
                    @(negedge i_clk);
                    rsp_if.ready <= 1'b1;
                end
                repeat (rand_gap()) begin
                    @(negedge i_clk);
                    rsp_if.ready <= 1'b0;
                end
            end
        end
    end

    // response monitor: every transaction on o_rsp is compared with the oldest owed one
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready)
                sb.check_response(rsp_if.ok, rsp_if.read_value, rsp_if.count);
        end
    end

    // stimulus
    initial begin
        t_phase ph;
        bit     burst;

        sb            = new();
        long_hold_req = 1'b0;
        i_rst_n       = 1'b0;
        req_if.valid  = 1'b0;
        req_if.mode   = OP_PUSH;
        req_if.index  = '0;
        req_if.value  = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty-list refusals first
        send_gapped(OP_POP,    '0,            '0);
        send_gapped(OP_REMOVE, '0,            '0);
        send_gapped(OP_GET,    '0,            '0);
        send_gapped(OP_SET,    ALL_ONES[5:0], ALL_ONES);
        // a few elements at the value extremes
        send_gapped(OP_PUSH,   '0,            '0);
        send_gapped(OP_PUSH,   ALL_ONES[5:0], ALL_ONES);
        send_gapped(OP_PUSH,   '0,            32'ha5a5_5a5a);
        send_gapped(OP_GET,    6'd0,          '0);
        send_gapped(OP_GET,    6'd2,          '0);
        // index equal to the count is out of range
        send_gapped(OP_GET,    6'd3,          '0);
        send_gapped(OP_SET,    6'd1,          32'h1234_5678);
        send_gapped(OP_GET,    6'd1,          '0);
        // remove at the head shifts the rest down
        send_gapped(OP_REMOVE, 6'd0,          '0);
        send_gapped(OP_GET,    6'd0,          '0);
        send_gapped(OP_REMOVE, ALL_ONES[5:0], '0);
        send_gapped(OP_SET,    ALL_ONES[5:0], ALL_ONES);
        // spare modes do nothing
        send_gapped(MODE_SPARE_LO,                 ALL_ONES[5:0], ALL_ONES);
        send_gapped(MODE_W'(MODE_SPARE_LO + 3'd1), 6'd0,          ALL_ONES);
        send_gapped(MODE_SPARE_HI,                 ALL_ONES[5:0], '0);
        // drain past empty
        send_gapped(OP_POP,    '0,            '0);
        send_gapped(OP_POP,    '0,            '0);
        send_gapped(OP_POP,    '0,            '0);
        wait_drained();

        // random phases alternate growth, shrinkage and churn so the list
        // keeps reaching both full and empty
        for (int p = 0; p < N_PHASES; p++) begin
            ph    = t_phase'(p % 3);
            burst = (p % 4 == 3) || (p == 5);
            if (p == 5)
                long_hold_req = 1'b1;
            for (int k = 0; k < PHASE_LEN; k++) begin
                if (!burst)
                    idle_req(rand_gap());
                send_req(pick_mode(ph), pick_index(), pick_value());
            end
            if (p % 5 == 4)
                wait_drained();
        end

        // finish: collect every owed response, then allow for stragglers
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        sb.check_leftovers();

        $display("covered %0d requests: %0d refused, %0d remove compactions",
                 sb.n_requests, sb.n_refused, sb.n_compactions);
        $display("push on a full list %0d times, pop on an empty list %0d times",
                 sb.n_full_hits, sb.n_empty_hits);
        if (sb.n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", sb.n_errors);
            $display("simulation failed");
        end
        $finish;
    end

endmodule
